[rtl/core/spg_pkg.sv]
// ----------------------------------------------------------------------------
// spg_pkg
// Shared widths, codes and types for the servo pulse train generator.
// ----------------------------------------------------------------------------
package spg_pkg;

  // field widths
  localparam int CHAN_W  = 5;
  localparam int WIDTH_W = 16;
  localparam int TIMER_W = 16;

  // default channel count and neutral pulse width
  localparam int NUM_CHANNELS_DEF = 20;
  localparam logic [WIDTH_W-1:0] NEUTRAL_WIDTH = 16'd3000;

  // item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // width write toward a bank
  typedef struct packed {
    logic               en;
    logic [CHAN_W-1:0]  chan;
    logic [WIDTH_W-1:0] data;
  } spg_wr_t;

  // what a bank did on one tick
  typedef struct packed {
    logic              pulse;
    logic [CHAN_W-1:0] chan;
    logic              frame_end;
  } spg_res_t;

endpackage

[rtl/core/spg_ram.sv]
// ----------------------------------------------------------------------------
// spg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/spg_bank.sv]
// ----------------------------------------------------------------------------
// spg_bank
// One servo bank: width table slice in RAM, compare value and channel index.
// The RAM is read ahead at the index the bank will hold next cycle.
// ----------------------------------------------------------------------------
module spg_bank
  import spg_pkg::*;
#(
  parameter int FIRST = 0,
  parameter int COUNT = 10,
  localparam int AW = (COUNT > 1) ? $clog2(COUNT) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  logic [TIMER_W-1:0] timer,
  input  spg_wr_t            wr,
  output spg_res_t           res
);

  localparam logic [CHAN_W-1:0] FirstIdx = CHAN_W'(FIRST);
  localparam logic [CHAN_W-1:0] LastIdx  = CHAN_W'(FIRST + COUNT - 1);

  logic [TIMER_W-1:0] compare;
  logic [TIMER_W-1:0] compare_next;
  logic [CHAN_W-1:0]  index;
  logic [CHAN_W-1:0]  index_next;
  logic [CHAN_W-1:0]  index_rel;
  logic [CHAN_W-1:0]  wr_rel;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               wr_hit;
  logic [COUNT-1:0]   written;
  logic               rd_valid;
  logic               fwd_valid;
  logic [WIDTH_W-1:0] fwd_data;
  logic [WIDTH_W-1:0] rdata;
  logic [WIDTH_W-1:0] width_cur;
  logic               match;
  logic               wrap;

  // write decode into the local slice
  assign wr_hit = wr.en && (wr.chan >= FirstIdx) && (wr.chan <= LastIdx);
  assign wr_rel = wr.chan - FirstIdx;
  assign waddr  = wr_rel[AW-1:0];

  // width of the current channel: forwarded write, stored entry or neutral
  always_comb begin
    if (fwd_valid) begin
      width_cur = fwd_data;
    end else if (rd_valid) begin
      width_cur = rdata;
    end else begin
      width_cur = NEUTRAL_WIDTH;
    end
  end

  // compare match, advance and index step
  assign match        = tick && (timer == compare);
  assign wrap         = (index == LastIdx);
  assign compare_next = match ? compare + width_cur : compare;

  always_comb begin
    index_next = index;
    if (match) begin
      index_next = wrap ? FirstIdx : index + CHAN_W'(1);
    end
  end

  // read ahead at the next index
  assign index_rel = index_next - FirstIdx;
  assign raddr     = index_rel[AW-1:0];

  // bank result
  always_comb begin
    res.pulse     = match;
    res.chan      = match ? index : '0;
    res.frame_end = match && wrap;
  end

  spg_ram #(
    .WIDTH (WIDTH_W),
    .DEPTH (COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_hit),
    .waddr (waddr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // bank state
  always_ff @(posedge clk) begin
    if (rst) begin
      compare <= '0;
      index   <= FirstIdx;
    end else begin
      compare <= compare_next;
      index   <= index_next;
    end
  end

  // written flags, read-valid and write forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      rd_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (wr_hit) begin
        written[waddr] <= 1'b1;
      end
      rd_valid  <= written[raddr];
      fwd_valid <= wr_hit && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr.data;
  end

  // checks
  a_frame_has_pulse: assert property (@(posedge clk) disable iff (rst)
    res.frame_end |-> res.pulse)
    else $error("frame end without clock pulse");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !tick |=> ($stable(index) && $stable(compare)))
    else $error("bank state moved without a tick");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (index >= FirstIdx) && (index <= LastIdx))
    else $error("bank index out of its half");

endmodule

[rtl/core/servo_pulse_train_generator.sv]
// ----------------------------------------------------------------------------
// servo_pulse_train_generator
// Two-bank multiplexed servo clock pulse generator with a writable width
// table and a free-running tick timer.
//
//   channel  direction  handshake             beat fields
//   in       sink       in_valid / in_stall   kind, channel, width
//   out      source     out_valid / out_stall clock_pulse_a/b, channel_a/b,
//                                             frame_end_a/b
//
// One item per cycle while in_stall is low; each item's result beat is registered
// and shows in the following cycle. Each bank keeps its table slice in a one-port-read
// RAM read ahead at the next index; writes to that entry are forwarded.
// The table reads neutral until an entry is written.
// in_stall is high only while a result beat waits under out_stall.
// ----------------------------------------------------------------------------
module servo_pulse_train_generator
  import spg_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [CHAN_W-1:0]  channel,
  input  logic [WIDTH_W-1:0] width,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               clock_pulse_a,
  output logic               clock_pulse_b,
  output logic [CHAN_W-1:0]  channel_a,
  output logic [CHAN_W-1:0]  channel_b,
  output logic               frame_end_a,
  output logic               frame_end_b
);

  localparam int HALF = NUM_CHANNELS / 2;

  logic               accept;
  logic               tick;
  logic [TIMER_W-1:0] timer;
  spg_wr_t            wr;
  spg_res_t           res_a;
  spg_res_t           res_b;

  // handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign tick     = accept && (kind == KIND_TICK);

  always_comb begin
    wr.en   = accept && (kind == KIND_WRITE);
    wr.chan = channel;
    wr.data = width;
  end

  // free-running timer
  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else if (tick) begin
      timer <= timer + TIMER_W'(1);
    end
  end

  spg_bank #(
    .FIRST (0),
    .COUNT (HALF)
  ) u_bank_a (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .timer (timer),
    .wr    (wr),
    .res   (res_a)
  );

  spg_bank #(
    .FIRST (HALF),
    .COUNT (NUM_CHANNELS - HALF)
  ) u_bank_b (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .timer (timer),
    .wr    (wr),
    .res   (res_b)
  );

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      clock_pulse_a <= res_a.pulse;
      clock_pulse_b <= res_b.pulse;
      channel_a     <= res_a.chan;
      channel_b     <= res_b.chan;
      frame_end_a   <= res_a.frame_end;
      frame_end_b   <= res_b.frame_end;
    end
  end

  // checks
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_WRITE)) |=>
      (out_valid && !clock_pulse_a && !clock_pulse_b))
    else $error("width write produced a clock pulse");

  a_timer_step: assert property (@(posedge clk) disable iff (rst)
    tick |=> (timer == $past(timer) + TIMER_W'(1)))
    else $error("timer did not advance on tick");

  a_chan_a_half: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clock_pulse_a) |-> (channel_a < CHAN_W'(HALF)))
    else $error("bank A reported a channel of bank B");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-bank servo pulse train generator. A short
// table of width writes and ticks opens the run, then random streams of
// ticks and width writes with small widths keep both banks cycling through
// their frames. The run closes with extreme widths loaded into both banks.
// Each result beat is checked per field against an in-bench model or fixed row.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spg_pkg::*;

  localparam int NCH          = NUM_CHANNELS_DEF;
  localparam int HALF         = NCH / 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PLAN_TARGET  = 1090;
  localparam int DIR_ROWS     = 16;

  // what both banks did on one beat
  typedef struct packed {
    spg_res_t a;
    spg_res_t b;
  } train_beat_t;

  typedef struct packed {
    logic               kind;
    logic [CHAN_W-1:0]  chan;
    logic [WIDTH_W-1:0] wid;
    logic               fixed;
    train_beat_t        want;
  } directed_row_t;

  typedef struct {
    logic               kind;
    logic [CHAN_W-1:0]  chan;
    logic [WIDTH_W-1:0] wid;
    bit                 fixed;
    train_beat_t        want;
    int                 pace;
  } servo_item_t;

  localparam train_beat_t NO_PULSE   = '0;
  localparam train_beat_t FIRST_TICK = '{
    a: '{pulse: 1'b1, chan: CHAN_W'(0), frame_end: 1'b0},
    b: '{pulse: 1'b1, chan: CHAN_W'(HALF), frame_end: 1'b0}
  };

  // opening table: rows with fixed set carry their own expected beat
  localparam directed_row_t DIRECTED [DIR_ROWS] = '{
    // writes past the table are dropped
    '{KIND_WRITE, 5'd31, 16'hFFFF, 1'b1, NO_PULSE},
    '{KIND_WRITE, 5'd20, 16'hFFFF, 1'b1, NO_PULSE},
    // zero width on the last channel, replaced before bank B gets there
    '{KIND_WRITE, 5'd19, 16'h0000, 1'b1, NO_PULSE},
    // short widths at the head of both banks
    '{KIND_WRITE, 5'd0,  16'd1,    1'b1, NO_PULSE},
    '{KIND_WRITE, 5'd1,  16'd1,    1'b1, NO_PULSE},
    '{KIND_WRITE, 5'd2,  16'd2,    1'b1, NO_PULSE},
    '{KIND_WRITE, 5'd10, 16'd1,    1'b1, NO_PULSE},
    '{KIND_WRITE, 5'd11, 16'd3,    1'b1, NO_PULSE},
    '{KIND_WRITE, 5'd12, 16'd1,    1'b1, NO_PULSE},
    // first tick out of reset fires both banks
    '{KIND_TICK,  5'd0,  16'd0,    1'b1, FIRST_TICK},
    '{KIND_TICK,  5'd31, 16'hFFFF, 1'b0, NO_PULSE},
    '{KIND_TICK,  5'd0,  16'd0,    1'b0, NO_PULSE},
    '{KIND_TICK,  5'd5,  16'h5A5A, 1'b0, NO_PULSE},
    // rewrite of the entry bank A reads next
    '{KIND_WRITE, 5'd3,  16'hFFFF, 1'b1, NO_PULSE},
    '{KIND_WRITE, 5'd3,  16'd1,    1'b1, NO_PULSE},
    '{KIND_TICK,  5'd0,  16'd0,    1'b0, NO_PULSE}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic [CHAN_W-1:0]  channel;
  logic [WIDTH_W-1:0] width;
  logic               out_valid;
  logic               out_stall;
  logic               clock_pulse_a;
  logic               clock_pulse_b;
  logic [CHAN_W-1:0]  channel_a;
  logic [CHAN_W-1:0]  channel_b;
  logic               frame_end_a;
  logic               frame_end_b;

  // model state of the generator
  logic [TIMER_W-1:0] tick_count;
  logic [TIMER_W-1:0] due_a;
  logic [TIMER_W-1:0] due_b;
  logic [CHAN_W-1:0]  slot_a;
  logic [CHAN_W-1:0]  slot_b;
  logic [WIDTH_W-1:0] width_tab [NCH];

  servo_item_t plan_q [$];
  train_beat_t pulse_due_q [$];

  int sink_pace = 0;
  int mismatch_cnt = 0;
  int tick_cnt = 0;
  int write_cnt = 0;
  int pulse_a_cnt = 0;
  int pulse_b_cnt = 0;
  int frame_a_cnt = 0;
  int frame_b_cnt = 0;
  int dual_cnt = 0;

  servo_pulse_train_generator #(
    .NUM_CHANNELS(NCH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .channel      (channel),
    .width        (width),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .clock_pulse_a(clock_pulse_a),
    .clock_pulse_b(clock_pulse_b),
    .channel_a    (channel_a),
    .channel_b    (channel_b),
    .frame_end_a  (frame_end_a),
    .frame_end_b  (frame_end_b)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // one bank: pulse on a compare hit, move the compare by the current width
  task automatic step_bank(input logic [TIMER_W-1:0] now, inout logic [TIMER_W-1:0] due,
                           inout logic [CHAN_W-1:0] slot, input int first_ch,
                           input int last_ch, output spg_res_t res);
    res = '0;
    if (now == due) begin
      res.pulse = 1'b1;
      res.chan  = slot;
      due       = due + width_tab[slot];
      if (slot == last_ch) begin
        slot          = CHAN_W'(first_ch);
        res.frame_end = 1'b1;
      end else begin
        slot = slot + 1'b1;
      end
    end
  endtask

  // expected beat for one accepted input beat
  task automatic predict_train(input logic k, input logic [CHAN_W-1:0] ch,
                               input logic [WIDTH_W-1:0] w, output train_beat_t beat);
    logic [TIMER_W-1:0] now;
    spg_res_t res_a;
    spg_res_t res_b;
    res_a = '0;
    res_b = '0;
    now   = tick_count;
    if (k == KIND_WRITE) begin
      if (ch < NCH) begin
        width_tab[ch] = w;
      end
    end else begin
      step_bank(now, due_a, slot_a, 0, HALF - 1, res_a);
      step_bank(now, due_b, slot_b, HALF, NCH - 1, res_b);
      tick_count = tick_count + 1'b1;
    end
    beat = '{a: res_a, b: res_b};
  endtask

  task automatic add_item(input logic k, input logic [CHAN_W-1:0] ch,
                          input logic [WIDTH_W-1:0] w, input int pace);
    servo_item_t item;
    item.kind  = k;
    item.chan  = ch;
    item.wid   = w;
    item.fixed = 1'b0;
    item.want  = NO_PULSE;
    item.pace  = pace;
    plan_q.push_back(item);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("time %0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    train_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pulse_due_q.size() == 0) begin
        $display("time %0t: beat expected none, got pulse a/b %0d/%0d chan a/b %0d/%0d",
                 $time, clock_pulse_a, clock_pulse_b, channel_a, channel_b);
        mismatch_cnt++;
      end else begin
        want = pulse_due_q.pop_front();
        check_field("clock_pulse_a", want.a.pulse, clock_pulse_a);
        check_field("clock_pulse_b", want.b.pulse, clock_pulse_b);
        check_field("channel_a", want.a.chan, channel_a);
        check_field("channel_b", want.b.chan, channel_b);
        check_field("frame_end_a", want.a.frame_end, frame_end_a);
        check_field("frame_end_b", want.b.frame_end, frame_end_b);
      end
      pulse_a_cnt += clock_pulse_a;
      pulse_b_cnt += clock_pulse_b;
      frame_a_cnt += frame_end_a;
      frame_b_cnt += frame_end_b;
      dual_cnt    += clock_pulse_a & clock_pulse_b;
    end
  end

  // result side stalls in bursts, as busy as the sender currently is
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && sink_pace > 0 && $urandom_range(0, 99) < sink_pace) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d beats still due", cycle_cnt, pulse_due_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    servo_item_t item;
    train_beat_t beat;
    logic [CHAN_W-1:0] ch;
    int pace;
    int seg_len;

    rst      = 1'b1;
    in_valid = 1'b0;
    kind     = KIND_TICK;
    channel  = '0;
    width    = '0;

    // model reset
    tick_count = '0;
    due_a      = '0;
    due_b      = '0;
    slot_a     = '0;
    slot_b     = CHAN_W'(HALF);
    for (int c = 0; c < NCH; c++) begin
      width_tab[c] = NEUTRAL_WIDTH;
    end

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      item.kind  = DIRECTED[r].kind;
      item.chan  = DIRECTED[r].chan;
      item.wid   = DIRECTED[r].wid;
      item.fixed = DIRECTED[r].fixed;
      item.want  = DIRECTED[r].want;
      item.pace  = 15;
      plan_q.push_back(item);
    end

    // refresh every channel with a short width before the random streams
    for (int c = 0; c < NCH; c++) begin
      add_item(KIND_WRITE, CHAN_W'(c), WIDTH_W'($urandom_range(1, 6)), 10);
    end

    // random segments: mostly ticks, some width writes, a few dropped writes
    while (plan_q.size() < PLAN_TARGET) begin
      case ($urandom_range(0, 2))
        0:       pace = 0;
        1:       pace = 8;
        default: pace = 25;
      endcase
      seg_len = $urandom_range(20, 60);
      repeat (seg_len) begin
        if ($urandom_range(0, 3) != 0) begin
          // tick payload fields are don't-care
          add_item(KIND_TICK, CHAN_W'($urandom_range(0, 31)),
                   WIDTH_W'($urandom_range(0, 65535)), pace);
        end else begin
          if ($urandom_range(0, 7) == 0) begin
            ch = CHAN_W'($urandom_range(NCH, 31));
          end else begin
            ch = CHAN_W'($urandom_range(0, NCH - 1));
          end
          // wide value, overwritten before any bank can load it
          if ($urandom_range(0, 7) == 0) begin
            add_item(KIND_WRITE, ch, WIDTH_W'($urandom_range(0, 65535)), pace);
          end
          add_item(KIND_WRITE, ch, WIDTH_W'($urandom_range(1, 8)), pace);
        end
      end
    end

    // closing part, no idling: full-scale widths on bank A, zero on bank B
    for (int c = 0; c < NCH; c++) begin
      add_item(KIND_WRITE, CHAN_W'(c), (c < HALF) ? 16'hFFFF : 16'h0000, 0);
    end
    repeat (40) begin
      add_item(KIND_TICK, '0, '0, 0);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // drive beats in order, with random gaps
    foreach (plan_q[i]) begin
      item      = plan_q[i];
      sink_pace = item.pace;
      if (item.pace > 0 && $urandom_range(0, 99) < item.pace) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      in_valid <= 1'b1;
      kind     <= item.kind;
      channel  <= item.chan;
      width    <= item.wid;
      do begin
        @(posedge clk);
      end while (in_stall);
      predict_train(item.kind, item.chan, item.wid, beat);
      pulse_due_q.push_back(item.fixed ? item.want : beat);
      if (item.kind == KIND_WRITE) begin
        write_cnt++;
      end else begin
        tick_cnt++;
      end
    end
    in_valid  <= 1'b0;
    sink_pace = 0;

    while (pulse_due_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d ticks and %0d width writes, %0d ticks firing both banks",
             tick_cnt, write_cnt, dual_cnt);
    $display("bank A: %0d pulses, %0d frame ends; bank B: %0d pulses, %0d frame ends",
             pulse_a_cnt, frame_a_cnt, pulse_b_cnt, frame_b_cnt);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
